/* hw/rtl/ac_pkg.sv */
// Shared types, constants and helpers for the multi-keyword matcher.
package ac_pkg;

    localparam int MAX_NODES     = 256;
    localparam int ALPHABET_SIZE = 26;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int CNT_W         = 16;
    localparam int SYM_W         = 5;
    localparam int EDGES         = MAX_NODES * ALPHABET_SIZE;
    localparam int EDGE_W        = $clog2(EDGES);
    localparam int TOTAL_W       = 48;
    localparam int SCAN_W        = 32;
    localparam int NTOT_W        = NODE_W + 1;

    localparam logic [SYM_W-1:0]  SYM_LAST  = SYM_W'(ALPHABET_SIZE - 1);
    localparam logic [NTOT_W-1:0] NTOT_FULL = NTOT_W'(MAX_NODES);

    localparam logic [2:0] MODE_KEY_LETTER = 3'd0;
    localparam logic [2:0] MODE_KEY_END    = 3'd1;
    localparam logic [2:0] MODE_BUILD      = 3'd2;
    localparam logic [2:0] MODE_TEXT       = 3'd3;
    localparam logic [2:0] MODE_CLEAR      = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [2:0]       mode;
        logic [SYM_W-1:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [TOTAL_W-1:0] match_total;
        logic [SCAN_W-1:0]  letters_scanned;
        logic [NTOT_W-1:0]  nodes_used;
    } out_item_t;

    typedef enum logic [4:0] {
        S_SWEEP, S_IDLE, S_DECODE, S_KEY, S_END,
        S_R_RD, S_R_PROC,
        S_B_HEAD, S_B_U, S_B_F, S_B_CU, S_B_CF, S_B_RD1, S_B_RD2, S_B_PROC,
        S_T_GOTO, S_T_CNT, S_RESULT
    } ac_state_t;

    // Flat goto-table address of one edge: node times alphabet plus letter.
    function automatic logic [EDGE_W-1:0] edge_addr(input logic [NODE_W-1:0] node,
                                                    input logic [SYM_W-1:0] sym);
        return EDGE_W'(node) * EDGE_W'(ALPHABET_SIZE) + EDGE_W'(sym);
    endfunction

endpackage

/* hw/rtl/aho_corasick_matcher.sv */
// Top level: multi-keyword matcher with registered result beat.
//
//   channel  | handshake                    | payload
//   item     | item_valid / item_ready      | item   (in_item_t: mode, symbol)
//   result   | result_valid / result_ready  | result (out_item_t)
//
// A text letter reads the goto table, then the count table. Build time grows
// with the number of trie nodes, limited by the single goto-table read port.
// Reset and clear sweep the 6656-entry goto table, one entry a cycle; no item
// is taken during the sweep. One item is in work at a time; the next is taken
// while a result waits in the output register.
module aho_corasick_matcher
    import ac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic      core_res_valid;
    logic      core_res_ready;
    out_item_t core_res;
    logic      result_valid_reg;
    out_item_t result_reg;

    ac_core u_core (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .res_valid(core_res_valid),
        .res_ready(core_res_ready),
        .res(core_res)
    );

    // Take a result when the output register is empty or draining
    assign core_res_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (core_res_ready)
        begin
            result_valid_reg <= core_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res_ready && core_res_valid)
        begin
            result_reg <= core_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        core_res_valid && result_valid && !result_ready |=> core_res_valid)
        else $error("core result lost");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        core_res_valid && core_res_ready |=> result_valid)
        else $error("result not loaded");
`endif

endmodule

/* hw/rtl/ac_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ac_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ac_core.sv */
// Sequencer and automaton memories: trie insert, link build, text scan, clear.
module ac_core
    import ac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res
);

    ac_state_t state_reg, state_next;

    logic [2:0]         mode_reg, mode_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic [NTOT_W-1:0]  ntot_reg, ntot_next;
    logic [NODE_W-1:0]  cursor_reg, cursor_next;
    logic [NODE_W-1:0]  scan_reg, scan_next;
    logic               built_reg, built_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [SCAN_W-1:0]  scanct_reg, scanct_next;
    logic [NTOT_W-1:0]  head_reg, head_next;
    logic [NTOT_W-1:0]  tail_reg, tail_next;
    logic [NODE_W-1:0]  u_reg, u_next;
    logic [NODE_W-1:0]  f_reg, f_next;
    logic [CNT_W-1:0]   cu_reg, cu_next;
    logic [NODE_W:0]    du_reg, du_next;
    logic [SYM_W-1:0]   c_reg, c_next;
    logic [EDGE_W-1:0]  sweep_reg, sweep_next;
    logic               reply_reg, reply_next;
    logic [1:0]         status_reg, status_next;

    logic              g_we;
    logic [EDGE_W-1:0] g_waddr, g_raddr;
    logic [NODE_W:0]   g_wdata, g_rdata;
    logic              f_we;
    logic [NODE_W-1:0] f_waddr, f_raddr, f_wdata, f_rdata;
    logic              n_we;
    logic [NODE_W-1:0] n_waddr, n_raddr;
    logic [CNT_W-1:0]  n_wdata, n_rdata;
    logic              q_we;
    logic [NODE_W-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

    logic [CNT_W:0]     cnt_sum;
    logic [TOTAL_W:0]   total_sum;

    // Goto table: present bit over target node
    ac_ram #(.DEPTH(EDGES), .WIDTH(NODE_W + 1)) u_goto (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    ac_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fail (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    ac_ram #(.DEPTH(MAX_NODES), .WIDTH(CNT_W)) u_count (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    ac_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // State and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_SWEEP;
            mode_reg   <= '0;
            sym_reg    <= '0;
            ntot_reg   <= NTOT_W'(1);
            cursor_reg <= '0;
            scan_reg   <= '0;
            built_reg  <= 1'b0;
            total_reg  <= '0;
            scanct_reg <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            u_reg      <= '0;
            f_reg      <= '0;
            cu_reg     <= '0;
            du_reg     <= '0;
            c_reg      <= '0;
            sweep_reg  <= '0;
            reply_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            sym_reg    <= sym_next;
            ntot_reg   <= ntot_next;
            cursor_reg <= cursor_next;
            scan_reg   <= scan_next;
            built_reg  <= built_next;
            total_reg  <= total_next;
            scanct_reg <= scanct_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            u_reg      <= u_next;
            f_reg      <= f_next;
            cu_reg     <= cu_next;
            du_reg     <= du_next;
            c_reg      <= c_next;
            sweep_reg  <= sweep_next;
            reply_reg  <= reply_next;
            status_reg <= status_next;
        end
    end

    assign res.status          = status_reg;
    assign res.match_total     = total_reg;
    assign res.letters_scanned = scanct_reg;
    assign res.nodes_used      = ntot_reg;

    // Next state, memory accesses and results
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        sym_next    = sym_reg;
        ntot_next   = ntot_reg;
        cursor_next = cursor_reg;
        scan_next   = scan_reg;
        built_next  = built_reg;
        total_next  = total_reg;
        scanct_next = scanct_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        u_next      = u_reg;
        f_next      = f_reg;
        cu_next     = cu_reg;
        du_next     = du_reg;
        c_next      = c_reg;
        sweep_next  = sweep_reg;
        reply_next  = reply_reg;
        status_next = status_reg;

        item_ready = 1'b0;
        res_valid  = 1'b0;
        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

        cnt_sum   = '0;
        total_sum = '0;

        unique case (state_reg)
            S_SWEEP:
            begin
                // Clear every edge, and link and count entries on the low rows
                g_we    = 1'b1;
                g_waddr = sweep_reg;
                f_we    = (sweep_reg < EDGE_W'(MAX_NODES));
                f_waddr = sweep_reg[NODE_W-1:0];
                n_we    = f_we;
                n_waddr = sweep_reg[NODE_W-1:0];
                if (sweep_reg == EDGE_W'(EDGES - 1))
                begin
                    sweep_next  = '0;
                    status_next = ST_OK;
                    state_next  = reply_reg ? S_RESULT : S_IDLE;
                    reply_next  = 1'b0;
                end
                else
                begin
                    sweep_next = sweep_reg + EDGE_W'(1);
                end
            end

            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    mode_next  = item.mode;
                    sym_next   = item.symbol;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next = ST_IGNORED;
                state_next  = S_RESULT;
                unique case (mode_reg)
                    MODE_KEY_LETTER:
                    begin
                        if (!built_reg && sym_reg <= SYM_LAST)
                        begin
                            g_raddr    = edge_addr(cursor_reg, sym_reg);
                            state_next = S_KEY;
                        end
                    end
                    MODE_KEY_END:
                    begin
                        if (!built_reg)
                        begin
                            n_raddr    = cursor_reg;
                            state_next = S_END;
                        end
                    end
                    MODE_BUILD:
                    begin
                        if (!built_reg)
                        begin
                            c_next     = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            state_next = S_R_RD;
                        end
                    end
                    MODE_TEXT:
                    begin
                        if (built_reg && sym_reg <= SYM_LAST)
                        begin
                            g_raddr    = edge_addr(scan_reg, sym_reg);
                            state_next = S_T_GOTO;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        ntot_next   = NTOT_W'(1);
                        cursor_next = '0;
                        scan_next   = '0;
                        built_next  = 1'b0;
                        total_next  = '0;
                        scanct_next = '0;
                        sweep_next  = '0;
                        reply_next  = 1'b1;
                        state_next  = S_SWEEP;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end

            S_KEY:
            begin
                // Follow an existing edge or allocate a new node
                status_next = ST_OK;
                if (g_rdata[NODE_W])
                begin
                    cursor_next = g_rdata[NODE_W-1:0];
                end
                else if (ntot_reg == NTOT_FULL)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    g_we        = 1'b1;
                    g_waddr     = edge_addr(cursor_reg, sym_reg);
                    g_wdata     = {1'b1, ntot_reg[NODE_W-1:0]};
                    cursor_next = ntot_reg[NODE_W-1:0];
                    ntot_next   = ntot_reg + NTOT_W'(1);
                end
                state_next = S_RESULT;
            end

            S_END:
            begin
                cnt_sum     = {1'b0, n_rdata} + (CNT_W + 1)'(1);
                n_we        = 1'b1;
                n_waddr     = cursor_reg;
                n_wdata     = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
                cursor_next = '0;
                status_next = ST_OK;
                state_next  = S_RESULT;
            end

            S_R_RD:
            begin
                g_raddr    = EDGE_W'(c_reg);
                state_next = S_R_PROC;
            end

            S_R_PROC:
            begin
                // Root edges: queue children, loop missing letters to the root
                if (g_rdata[NODE_W])
                begin
                    if (!tail_reg[NODE_W])
                    begin
                        q_we      = 1'b1;
                        q_waddr   = tail_reg[NODE_W-1:0];
                        q_wdata   = g_rdata[NODE_W-1:0];
                        tail_next = tail_reg + NTOT_W'(1);
                    end
                    f_we    = 1'b1;
                    f_waddr = g_rdata[NODE_W-1:0];
                    f_wdata = '0;
                end
                else
                begin
                    g_we    = 1'b1;
                    g_waddr = EDGE_W'(c_reg);
                    g_wdata = {1'b1, {NODE_W{1'b0}}};
                end
                if (c_reg == SYM_LAST)
                begin
                    state_next = S_B_HEAD;
                end
                else
                begin
                    c_next     = c_reg + SYM_W'(1);
                    state_next = S_R_RD;
                end
            end

            S_B_HEAD:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next  = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_RESULT;
                end
                else
                begin
                    q_raddr    = head_reg[NODE_W-1:0];
                    head_next  = head_reg + NTOT_W'(1);
                    state_next = S_B_U;
                end
            end

            S_B_U:
            begin
                u_next     = q_rdata;
                f_raddr    = q_rdata;
                state_next = S_B_F;
            end

            S_B_F:
            begin
                f_next     = f_rdata;
                n_raddr    = u_reg;
                state_next = S_B_CU;
            end

            S_B_CU:
            begin
                cu_next    = n_rdata;
                n_raddr    = f_reg;
                state_next = S_B_CF;
            end

            S_B_CF:
            begin
                // Inherit the failure node's match count
                cnt_sum    = {1'b0, cu_reg} + {1'b0, n_rdata};
                n_we       = 1'b1;
                n_waddr    = u_reg;
                n_wdata    = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
                c_next     = '0;
                state_next = S_B_RD1;
            end

            S_B_RD1:
            begin
                g_raddr    = edge_addr(u_reg, c_reg);
                state_next = S_B_RD2;
            end

            S_B_RD2:
            begin
                du_next    = g_rdata;
                g_raddr    = edge_addr(f_reg, c_reg);
                state_next = S_B_PROC;
            end

            S_B_PROC:
            begin
                // Link a child through the failure node, or fill the missing edge
                if (du_reg[NODE_W])
                begin
                    f_we    = 1'b1;
                    f_waddr = du_reg[NODE_W-1:0];
                    f_wdata = g_rdata[NODE_W-1:0];
                    if (!tail_reg[NODE_W])
                    begin
                        q_we      = 1'b1;
                        q_waddr   = tail_reg[NODE_W-1:0];
                        q_wdata   = du_reg[NODE_W-1:0];
                        tail_next = tail_reg + NTOT_W'(1);
                    end
                end
                else
                begin
                    g_we    = 1'b1;
                    g_waddr = edge_addr(u_reg, c_reg);
                    g_wdata = {1'b1, g_rdata[NODE_W-1:0]};
                end
                if (c_reg == SYM_LAST)
                begin
                    state_next = S_B_HEAD;
                end
                else
                begin
                    c_next     = c_reg + SYM_W'(1);
                    state_next = S_B_RD1;
                end
            end

            S_T_GOTO:
            begin
                scan_next  = g_rdata[NODE_W-1:0];
                n_raddr    = g_rdata[NODE_W-1:0];
                state_next = S_T_CNT;
            end

            S_T_CNT:
            begin
                // Accumulate matches and count the letter, both saturating
                total_sum   = {1'b0, total_reg} + (TOTAL_W + 1)'(n_rdata);
                total_next  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                if (scanct_reg != '1)
                begin
                    scanct_next = scanct_reg + SCAN_W'(1);
                end
                status_next = ST_OK;
                state_next  = S_RESULT;
            end

            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_ntot_range: assert property (@(posedge clk) disable iff (!rst_n)
        ntot_reg >= NTOT_W'(1) && ntot_reg <= NTOT_FULL)
        else $error("node count out of range");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result dropped before taken");

    a_built_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(built_reg) |-> $past(state_reg) == S_DECODE && $past(mode_reg) == MODE_CLEAR)
        else $error("build flag lost without clear");

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && res_valid))
        else $error("ready while result pending");
`endif

endmodule

/* dv/aho_corasick_matcher_tb.sv */
// Self-checking testbench for the multi-keyword matcher: directed and random item streams.
`timescale 1ns / 1ps

module testbench;
    import ac_pkg::*;

    localparam int  RESET_CYCLES = 9;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  ITEM_TARGET  = 450;
    localparam int  TAIL_CYCLES  = 200;
    localparam longint unsigned TOTAL_SAT = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned SCAN_SAT  = 64'hFFFF_FFFF;
    localparam int  CNT_SAT = (1 << CNT_W) - 1;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    aho_corasick_matcher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Shadow automaton state
    int              trie_next [EDGES];
    bit              trie_has  [EDGES];
    int              fail_node [MAX_NODES];
    int              hit_count [MAX_NODES];
    int              walk_fifo [MAX_NODES];
    int              node_cnt;
    int              ins_node;
    int              scan_node;
    bit              links_built;
    longint unsigned hits_total;
    longint unsigned scanned;

    out_item_t expected_results [$];
    int        mismatches = 0;
    int        counted_items = 0;
    int        burst_left = 0;
    int        hold_cnt = 0;
    longint    cycles = 0;

    always #5 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("aho_corasick_matcher verification failed");
            $finish;
        end
    end

    function automatic void clear_shadow();
        for (int i = 0; i < EDGES; i++)
        begin
            trie_next[i] = 0;
            trie_has[i]  = 1'b0;
        end
        for (int i = 0; i < MAX_NODES; i++)
        begin
            fail_node[i] = 0;
            hit_count[i] = 0;
        end
        node_cnt    = 1;
        ins_node    = 0;
        scan_node   = 0;
        links_built = 1'b0;
        hits_total  = 0;
        scanned     = 0;
    endfunction

    function automatic int sat_add_count(int a, int b);
        int s;
        s = a + b;
        return (s > CNT_SAT) ? CNT_SAT : s;
    endfunction

    // Breadth-first pass: failure links, goto completion, inherited counts
    function automatic void build_shadow_links();
        int head;
        int tail;
        int u;
        int f;
        int e;
        int via;
        int v;
        head = 0;
        tail = 0;
        for (int c = 0; c < ALPHABET_SIZE; c++)
        begin
            if (trie_has[c])
            begin
                if (tail < MAX_NODES)
                begin
                    walk_fifo[tail] = trie_next[c];
                    tail++;
                end
                fail_node[trie_next[c] % MAX_NODES] = 0;
            end
            else
            begin
                trie_next[c] = 0;
                trie_has[c]  = 1'b1;
            end
        end
        while (head < tail)
        begin
            u = walk_fifo[head] % MAX_NODES;
            head++;
            f = fail_node[u] % MAX_NODES;
            hit_count[u] = sat_add_count(hit_count[u], hit_count[f]);
            for (int c = 0; c < ALPHABET_SIZE; c++)
            begin
                e   = u * ALPHABET_SIZE + c;
                via = trie_next[f * ALPHABET_SIZE + c];
                if (trie_has[e])
                begin
                    v = trie_next[e] % MAX_NODES;
                    fail_node[v] = via;
                    if (tail < MAX_NODES)
                    begin
                        walk_fifo[tail] = v;
                        tail++;
                    end
                end
                else
                begin
                    trie_next[e] = via;
                    trie_has[e]  = 1'b1;
                end
            end
        end
        links_built = 1'b1;
    endfunction

    // Expected result beat for one accepted item
    function automatic out_item_t predict_matcher(in_item_t it);
        out_item_t r;
        int        sym;
        int        e;
        bit        sym_ok;
        logic [1:0] st;
        sym    = int'(it.symbol);
        sym_ok = (sym < ALPHABET_SIZE);
        st     = ST_IGNORED;
        case (it.mode)
            MODE_KEY_LETTER:
            begin
                if (!links_built && sym_ok)
                begin
                    e  = (ins_node % MAX_NODES) * ALPHABET_SIZE + sym;
                    st = ST_OK;
                    if (!trie_has[e])
                    begin
                        if (node_cnt >= MAX_NODES)
                            st = ST_FULL;
                        else
                        begin
                            trie_next[e] = node_cnt;
                            trie_has[e]  = 1'b1;
                            node_cnt++;
                        end
                    end
                    if (st == ST_OK)
                        ins_node = trie_next[e] % MAX_NODES;
                end
            end
            MODE_KEY_END:
            begin
                if (!links_built)
                begin
                    hit_count[ins_node] = sat_add_count(hit_count[ins_node], 1);
                    ins_node = 0;
                    st = ST_OK;
                end
            end
            MODE_BUILD:
            begin
                if (!links_built)
                begin
                    build_shadow_links();
                    st = ST_OK;
                end
            end
            MODE_TEXT:
            begin
                if (links_built && sym_ok)
                begin
                    scan_node  = trie_next[scan_node * ALPHABET_SIZE + sym] % MAX_NODES;
                    hits_total = hits_total + longint'(hit_count[scan_node]);
                    if (hits_total > TOTAL_SAT)
                        hits_total = TOTAL_SAT;
                    if (scanned < SCAN_SAT)
                        scanned++;
                    st = ST_OK;
                end
            end
            MODE_CLEAR:
            begin
                clear_shadow();
                st = ST_OK;
            end
            default:
                st = ST_IGNORED;
        endcase
        r.status          = st;
        r.match_total     = hits_total[TOTAL_W-1:0];
        r.letters_scanned = scanned[SCAN_W-1:0];
        r.nodes_used      = node_cnt[NTOT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
        mismatches++;
    endtask

    // Offer one beat, in bursts with random gaps, and log its expectation
    task automatic send_item(logic [2:0] mode, logic [SYM_W-1:0] sym);
        in_item_t  it;
        out_item_t exp_r;
        int        gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        it.mode   = mode;
        it.symbol = sym;
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        exp_r = predict_matcher(it);
        expected_results.push_back(exp_r);
        if (exp_r.status != ST_IGNORED)
            counted_items++;
    endtask

    // Receiver: check each accepted beat, then pick the next ready level
    int stall_style = 0;
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected beat", 1, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status != want.status)
                    report_mismatch("status", result.status, want.status);
                if (result.match_total != want.match_total)
                    report_mismatch("match_total", result.match_total, want.match_total);
                if (result.letters_scanned != want.letters_scanned)
                    report_mismatch("letters_scanned", result.letters_scanned,
                                    want.letters_scanned);
                if (result.nodes_used != want.nodes_used)
                    report_mismatch("nodes_used", result.nodes_used, want.nodes_used);
            end
        end
        if (cycles % 64 == 0)
            stall_style = $urandom_range(0, 2);
        if (!rst_n || hold_cnt > 0)
            result_ready <= 1'b0;
        else if (stall_style == 0)
            result_ready <= 1'b1;
        else if (stall_style == 1)
            result_ready <= $urandom_range(0, 1);
        else
            result_ready <= ($urandom_range(0, 3) == 0);
    end

    // Long receiver hold-off, counted down here
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    task automatic send_word(int letters[$]);
        foreach (letters[i])
            send_item(MODE_KEY_LETTER, SYM_W'(letters[i]));
        send_item(MODE_KEY_END, SYM_W'($urandom_range(0, 31)));
    endtask

    // Phase rules, bad symbols, unused modes, empty keyword, classic words
    task automatic test_directed();
        send_item(MODE_TEXT, 5'd0);
        send_item(MODE_KEY_END, 5'd31);
        send_word({7, 4});
        send_word({18, 7, 4});
        send_item(MODE_KEY_LETTER, 5'd26);
        send_item(MODE_KEY_LETTER, 5'd31);
        send_item(3'd5, 5'd0);
        send_item(3'd6, 5'd31);
        send_item(3'd7, 5'd25);
        send_item(MODE_BUILD, 5'd0);
        send_item(MODE_BUILD, 5'd31);
        send_item(MODE_KEY_LETTER, 5'd0);
        send_item(MODE_KEY_END, 5'd0);
        send_item(MODE_TEXT, 5'd18);
        send_item(MODE_TEXT, 5'd7);
        send_item(MODE_TEXT, 5'd4);
        send_item(MODE_TEXT, 5'd31);
        send_item(MODE_TEXT, 5'd25);
        send_item(MODE_CLEAR, 5'd31);
    endtask

    // Fill the node table with one long keyword while the receiver holds off
    task automatic test_table_full();
        hold_cnt <= 600;
        for (int i = 0; i < MAX_NODES + 2; i++)
            send_item(MODE_KEY_LETTER, SYM_W'($urandom_range(0, ALPHABET_SIZE - 1)));
        send_item(MODE_KEY_END, 5'd0);
        send_item(MODE_BUILD, 5'd0);
        for (int i = 0; i < 6; i++)
            send_item(MODE_TEXT, SYM_W'($urandom_range(0, ALPHABET_SIZE - 1)));
        send_item(MODE_CLEAR, 5'd0);
    endtask

    function automatic logic [SYM_W-1:0] pick_letter(int base, int span);
        return SYM_W'(base + $urandom_range(0, span - 1));
    endfunction

    task automatic send_noise();
        send_item(3'($urandom_range(0, 7)), SYM_W'($urandom_range(0, 31)));
    endtask

    // Random dictionaries over narrow letter ranges, then matching text
    task automatic test_random_phases();
        int base;
        int span;
        int words;
        int len;
        int letters[$];
        while (counted_items < ITEM_TARGET)
        begin
            span  = ($urandom_range(0, 4) == 0) ? ALPHABET_SIZE : $urandom_range(2, 4);
            base  = $urandom_range(0, ALPHABET_SIZE - span);
            words = $urandom_range(1, 8);
            for (int w = 0; w < words; w++)
            begin
                letters = {};
                len = $urandom_range(0, 5);
                for (int k = 0; k < len; k++)
                    letters.push_back(int'(pick_letter(base, span)));
                send_word(letters);
                if ($urandom_range(0, 9) == 0)
                    send_noise();
            end
            send_item(MODE_BUILD, SYM_W'($urandom_range(0, 31)));
            repeat ($urandom_range(20, 60))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_item(MODE_TEXT, pick_letter(base, span));
            end
            send_item(MODE_CLEAR, SYM_W'($urandom_range(0, 31)));
        end
    endtask

    initial
    begin
        clear_shadow();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random_phases();
        if (burst_left >= 0)
            item_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("aho_corasick_matcher verification clean");
        else
            $display("aho_corasick_matcher verification failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ac_pkg.sv
hw/rtl/ac_ram.sv
hw/rtl/ac_core.sv
hw/rtl/aho_corasick_matcher.sv
dv/aho_corasick_matcher_tb.sv
